// ----- sv/lcg48_pkg.sv -----
// lcg48_pkg: shared constants, payload structs and controller/datapath
// command and status types for the 48-bit LCG generator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lcg48_pkg;

    localparam int unsigned STATE_W   = 48;
    localparam int unsigned HALF_W    = STATE_W / 2;
    localparam int unsigned DIV_STEPS = 31;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    localparam logic [STATE_W-1:0] LCG_MULT = 48'h0005_DEEC_E66D;
    localparam logic [STATE_W-1:0] LCG_INC  = 48'h0000_0000_000B;

    // request kinds
    localparam logic [1:0] REQ_RAW     = 2'd0;
    localparam logic [1:0] REQ_BOUNDED = 2'd1;
    localparam logic [1:0] REQ_LONG    = 2'd2;
    localparam logic [1:0] REQ_DOUBLE  = 2'd3;

    // partial product selects for the shared 24x24 multiplier
    localparam logic [1:0] MUL_LO_LO = 2'd0;
    localparam logic [1:0] MUL_HI_LO = 2'd1;
    localparam logic [1:0] MUL_LO_HI = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [5:0]         bit_count;
        logic signed [31:0] bound;
    } t_req;

    typedef struct packed {
        logic signed [63:0] value;
        logic               bad_bound;
    } t_rsp;

    typedef struct packed {
        logic       load_req;
        logic       mul_en;
        logic [1:0] mul_step;
        logic       draw;
        logic       second;
        logic       div_step;
        logic       take_rem;
        logic       set_bad;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       bad_bnd;
        logic       pow2;
        logic       retry;
    } t_sts;

endpackage

`default_nettype wire

// ----- sv/lcg48_ctrl.sv -----
// lcg48_ctrl: request sequencer. Steps the multiplier, draws, the modulo
// loop and the response word hand-off. Depends on lcg48_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcg48_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    output logic                 o_req_ready,
    output logic                 o_rsp_valid,
    input  wire logic            i_rsp_ready,
    input  wire lcg48_pkg::t_sts i_sts,
    output lcg48_pkg::t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_MUL0, S_MUL1, S_MUL2, S_DRAW, S_DIV, S_TEST, S_FIN
    } t_state;

    t_state                         r_state, n_state;
    logic [lcg48_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic                           r_second, n_second;
    logic                           r_rsp_valid, n_rsp_valid;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_second    = r_second;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        o_cmd       = '0;
        o_cmd.second = r_second;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                n_second = 1'b0;
                if (i_sts.kind == lcg48_pkg::REQ_BOUNDED && i_sts.bad_bnd) begin
                    o_cmd.set_bad = 1'b1;
                    n_state       = S_FIN;
                end else begin
                    n_state = S_MUL0;
                end
            end
            S_MUL0: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_step = lcg48_pkg::MUL_LO_LO;
                n_state        = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_step = lcg48_pkg::MUL_HI_LO;
                n_state        = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_step = lcg48_pkg::MUL_LO_HI;
                n_state        = S_DRAW;
            end
            S_DRAW: begin
                o_cmd.draw = 1'b1;
                unique case (i_sts.kind)
                    lcg48_pkg::REQ_RAW: n_state = S_FIN;
                    lcg48_pkg::REQ_BOUNDED: begin
                        n_cnt   = '0;
                        n_state = i_sts.pow2 ? S_FIN : S_DIV;
                    end
                    default: begin
                        // long and mantissa take a second draw
                        if (!r_second) begin
                            n_second = 1'b1;
                            n_state  = S_MUL0;
                        end else begin
                            n_state  = S_FIN;
                        end
                    end
                endcase
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == lcg48_pkg::CNT_W'(lcg48_pkg::DIV_STEPS - 1)) begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (i_sts.retry) begin
                    n_state = S_MUL0;
                end else begin
                    o_cmd.take_rem = 1'b1;
                    n_state        = S_FIN;
                end
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_rsp_valid || i_rsp_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_rsp_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_second    <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_second    <= n_second;
            r_rsp_valid <= n_rsp_valid;
        end
    end

endmodule

`default_nettype wire

// ----- sv/lcg48_dp.sv -----
// lcg48_dp: generator state, shared 24x24 multiplier, draw extraction,
// restoring modulo unit and the response register. Depends on lcg48_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcg48_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    input  wire logic [lcg48_pkg::STATE_W-1:0] i_cfg_data,
    input  wire lcg48_pkg::t_req              i_req,
    input  wire lcg48_pkg::t_cmd              i_cmd,
    output lcg48_pkg::t_sts                   o_sts,
    output lcg48_pkg::t_rsp                   o_rsp
);

    localparam int unsigned SW = lcg48_pkg::STATE_W;
    localparam int unsigned HW = lcg48_pkg::HALF_W;

    logic [SW-1:0]      r_lcg;
    logic [SW-1:0]      r_acc;
    lcg48_pkg::t_req    r_req;
    logic [31:0]        r_hi;
    logic [30:0]        r_dvd;
    logic [30:0]        r_r;
    logic [30:0]        r_rem;
    logic [63:0]        r_val;
    logic               r_bad;
    lcg48_pkg::t_rsp    r_rsp;

    logic [HW-1:0]      mul_a, mul_b;
    logic [SW-1:0]      mul_p;
    logic [31:0]        bnd;
    logic [5:0]         nsat;
    logic [SW-1:0]      raw_sh;
    logic [31:0]        raw_bits;
    logic [62:0]        pow_p;
    logic [31:0]        lo32;
    logic [31:0]        rem_sh;
    logic               rem_ge;
    logic [31:0]        rej_sum;

    assign bnd = r_req.bound;

    // shared partial-product multiplier
    always_comb begin
        mul_a = (i_cmd.mul_step == lcg48_pkg::MUL_HI_LO) ? r_lcg[SW-1:HW] : r_lcg[HW-1:0];
        mul_b = (i_cmd.mul_step == lcg48_pkg::MUL_LO_HI) ? lcg48_pkg::LCG_MULT[SW-1:HW]
                                                         : lcg48_pkg::LCG_MULT[HW-1:0];
        mul_p = {{HW{1'b0}}, mul_a} * {{HW{1'b0}}, mul_b};
    end

    // draw extraction from the freshly advanced state
    always_comb begin
        nsat     = (r_req.bit_count > 6'd32) ? 6'd32 : r_req.bit_count;
        raw_sh   = r_lcg >> (6'd48 - nsat);
        raw_bits = raw_sh[31:0];
        pow_p    = {31'd0, bnd} * {32'd0, r_lcg[47:17]};
        lo32     = r_lcg[47:16];
        rem_sh   = {r_rem, r_dvd[30]};
        rem_ge   = (rem_sh >= bnd);
        rej_sum  = {1'b0, r_r} - {1'b0, r_rem} + bnd - 32'd1;
    end

    always_comb begin
        o_sts.kind    = r_req.req_type;
        o_sts.bad_bnd = (bnd == 32'd0) || bnd[31];
        o_sts.pow2    = ((bnd & (bnd - 32'd1)) == 32'd0);
        o_sts.retry   = rej_sum[31];
    end

    assign o_rsp = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcg <= lcg48_pkg::LCG_MULT;
        end else if (i_cfg_valid) begin
            r_lcg <= i_cfg_data ^ lcg48_pkg::LCG_MULT;
        end else if (i_cmd.mul_en && i_cmd.mul_step == lcg48_pkg::MUL_LO_HI) begin
            r_lcg <= {r_acc[SW-1:HW] + mul_p[HW-1:0], r_acc[HW-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_step)
                lcg48_pkg::MUL_LO_LO: r_acc <= mul_p + lcg48_pkg::LCG_INC;
                lcg48_pkg::MUL_HI_LO: r_acc[SW-1:HW] <= r_acc[SW-1:HW] + mul_p[HW-1:0];
                default: ;
            endcase
        end

        if (i_cmd.load_req) begin
            r_req <= i_req;
            r_bad <= 1'b0;
        end

        if (i_cmd.set_bad) begin
            r_val <= '0;
            r_bad <= 1'b1;
        end

        if (i_cmd.draw) begin
            case (r_req.req_type)
                lcg48_pkg::REQ_RAW: r_val <= {{32{raw_bits[31]}}, raw_bits};
                lcg48_pkg::REQ_BOUNDED: begin
                    if (o_sts.pow2) begin
                        r_val <= {{32{pow_p[62]}}, pow_p[62:31]};
                    end else begin
                        r_dvd <= r_lcg[47:17];
                        r_r   <= r_lcg[47:17];
                        r_rem <= '0;
                    end
                end
                lcg48_pkg::REQ_LONG: begin
                    if (!i_cmd.second) begin
                        r_hi <= lo32;
                    end else begin
                        r_val <= {r_hi, 32'd0} + {{32{lo32[31]}}, lo32};
                    end
                end
                default: begin
                    if (!i_cmd.second) begin
                        r_hi <= {6'd0, r_lcg[47:22]};
                    end else begin
                        r_val <= {11'd0, r_hi[25:0], r_lcg[47:21]};
                    end
                end
            endcase
        end

        // one remainder bit per cycle
        if (i_cmd.div_step) begin
            r_rem <= rem_ge ? 31'(rem_sh - bnd) : rem_sh[30:0];
            r_dvd <= {r_dvd[29:0], 1'b0};
        end

        if (i_cmd.take_rem) begin
            r_val <= {33'd0, r_rem};
        end

        if (i_cmd.out_load) begin
            r_rsp.value     <= r_val;
            r_rsp.bad_bound <= r_bad;
        end
    end

endmodule

`default_nettype wire

// ----- sv/lcg48_random_generator.sv -----
// lcg48_random_generator: top level of the 48-bit LCG generator.
// Instantiates lcg48_ctrl and lcg48_dp; depends on lcg48_pkg.
//
// channel | signals                          | word
// --------+----------------------------------+-----------------------------
// cfg     | i_cfg_valid/o_cfg_ready          | i_cfg_data, 48-bit seed
// req     | i_req_valid/o_req_ready          | i_req  (lcg48_pkg::t_req)
// rsp     | o_rsp_valid/i_rsp_ready          | o_rsp  (lcg48_pkg::t_rsp)
//
// One request at a time. Each state advance runs the lo*lo, hi*lo and lo*hi
// partial products on the shared 24x24 multiplier. Raw bits and power-of-two
// bounds take one draw, long or mantissa two, a bad bound none; other bounds
// add a 31-step modulo and a sign test, and a rejected draw starts over.
// A finished word waits in the output register while the next request runs.
// Reset sets the state to the scrambled zero seed; nothing to clear.
`timescale 1ns / 1ps
`default_nettype none

module lcg48_random_generator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [lcg48_pkg::STATE_W-1:0] i_cfg_data,
    input  wire logic                          i_req_valid,
    output logic                               o_req_ready,
    input  wire lcg48_pkg::t_req               i_req,
    output logic                               o_rsp_valid,
    input  wire logic                          i_rsp_ready,
    output lcg48_pkg::t_rsp                    o_rsp
);

    lcg48_pkg::t_cmd cmd;
    lcg48_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    lcg48_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    lcg48_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_rsp       (o_rsp)
    );

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.bad_bound) |-> (o_rsp.value == 64'sd0))
        else $error("bad bound word carries a nonzero value");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_req_ready)
        else $error("request taken while another is in flight");

    a_mul_div_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.mul_en && cmd.div_step))
        else $error("multiplier and modulo step active together");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_rsp_valid)
        else $error("output load did not raise response valid");

endmodule

`default_nettype wire
